// ===== rtl/binary_bit_trie_prefix_store_macros.svh =====
// Assertion helpers used by the top-level trie module.
`ifndef BINARY_BIT_TRIE_PREFIX_STORE_MACROS_SVH
`define BINARY_BIT_TRIE_PREFIX_STORE_MACROS_SVH

// Clocked assertion, disabled while reset is low.
`define BBT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Implication checked in the following cycle.
`define BBT_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== rtl/bbt_pkg.sv =====
`timescale 1ns / 1ps

package bbt_pkg;

  localparam int unsigned MaskWidth = 32;

  // Input transaction
  typedef struct packed {
    logic                 func;
    logic [MaskWidth-1:0] mask;
  } in_t;

  // Result transaction
  typedef struct packed {
    logic found;
    logic pool_full;
  } out_t;

  localparam logic FuncInsert = 1'b0;
  localparam logic FuncQuery  = 1'b1;

endpackage

// ===== rtl/bbt_key_cell.sv =====
`timescale 1ns / 1ps

// One key bit of the shift chain; hands its bit down one place per step.
module bbt_key_cell (
  input  logic clk_i,
  input  logic load_i,
  input  logic shift_i,
  input  logic load_bit_i,
  input  logic next_bit_i,
  input  logic next_any_i,
  output logic bit_o,
  output logic any_o
);

  logic key_q, key_d;

  always_comb begin
    key_d = key_q;
    if (load_i) begin
      key_d = load_bit_i;
    end else if (shift_i) begin
      key_d = next_bit_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  // any set bit at or above this cell
  assign bit_o = key_q;
  assign any_o = key_q | next_any_i;

endmodule

// ===== rtl/bbt_node_store.sv =====
`timescale 1ns / 1ps

// Node link memory: one write port, one registered read port.
module bbt_node_store #(
  parameter int unsigned Depth  = 1024,
  parameter int unsigned AddrW  = 10
) (
  input  logic               clk_i,
  input  logic               we_i,
  input  logic [AddrW-1:0]   waddr_i,
  input  logic [2*AddrW-1:0] wdata_i,
  input  logic               re_i,
  input  logic [AddrW-1:0]   raddr_i,
  output logic [2*AddrW-1:0] rdata_o
);

  logic [2*AddrW-1:0] mem_q [Depth];
  logic [2*AddrW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/binary_bit_trie_prefix_store.sv =====
`timescale 1ns / 1ps

// Binary trie of bit masks, walked least significant bit first up to the
// highest set bit. A transaction with func=0 inserts the path, allocating
// nodes from a pool of NODE_COUNT (pool_full=1 if it ran out, earlier nodes
// stay); func=1 reports found=1 when the whole path exists (always for a zero
// mask). One transaction at a time: the walk makes at most one node memory
// access per level, then a response state registers the result. An insert
// that allocates also writes the links of the last fresh node. The key sits
// in a chain of KEY_BITS one-bit cells that shifts one level per cycle while
// the walk advances. The root lives in flip-flops and every other node is
// written before its first read, so no clearing pass follows reset.
`include "binary_bit_trie_prefix_store_macros.svh"

module binary_bit_trie_prefix_store #(
  parameter int unsigned NODE_COUNT = 1024,
  parameter int unsigned KEY_BITS   = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  bbt_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output bbt_pkg::out_t out_data_o
);

  localparam int unsigned IdxW     = $clog2(NODE_COUNT);
  localparam int unsigned CntW     = IdxW + 1;
  localparam int unsigned LoadBits = (KEY_BITS < bbt_pkg::MaskWidth) ?
                                     KEY_BITS : bbt_pkg::MaskWidth;
  localparam logic [CntW-1:0] NodeLimit = CntW'(NODE_COUNT);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_WALK  = 2'd1;
  localparam logic [1:0] ST_ALLOC = 2'd2;
  localparam logic [1:0] ST_RESP  = 2'd3;

  logic [1:0]        state_q, state_d;
  logic              is_query_q, is_query_d;
  logic              at_root_q, at_root_d;
  logic [IdxW-1:0]   cur_q, cur_d;
  logic [CntW-1:0]   used_q, used_d;
  logic [2*IdxW-1:0] root_q, root_d;
  logic              res_found_q, res_found_d;
  logic              res_full_q, res_full_d;
  logic              out_valid_q, out_valid_d;
  bbt_pkg::out_t     out_q, out_d;

  logic              accept, load_out, shift;
  logic [KEY_BITS:0] key_bit, key_any;
  logic              mem_we, mem_re;
  logic [IdxW-1:0]   mem_waddr, mem_raddr;
  logic [2*IdxW-1:0] mem_wdata, mem_rdata, links, links_set;
  logic [IdxW-1:0]   child, new_idx;
  logic              pool_empty, key_nz;
  logic              walk_query;

  assign accept = in_valid_i && !in_stall_o;

  // key shift chain
  assign key_bit[KEY_BITS] = 1'b0;
  assign key_any[KEY_BITS] = 1'b0;

  for (genvar i = 0; i < KEY_BITS; i++) begin : g_cell
    logic load_bit;
    if (i < bbt_pkg::MaskWidth) begin : g_ld
      assign load_bit = in_data_i.mask[i];
    end else begin : g_zero
      assign load_bit = 1'b0;
    end
    bbt_key_cell u_cell (
      .clk_i      (clk_i),
      .load_i     (accept),
      .shift_i    (shift),
      .load_bit_i (load_bit),
      .next_bit_i (key_bit[i+1]),
      .next_any_i (key_any[i+1]),
      .bit_o      (key_bit[i]),
      .any_o      (key_any[i])
    );
  end

  bbt_node_store #(
    .Depth (NODE_COUNT),
    .AddrW (IdxW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // current node links and the child on this level's bit
  assign links      = at_root_q ? root_q : mem_rdata;
  assign child      = key_bit[0] ? links[2*IdxW-1:IdxW] : links[IdxW-1:0];
  assign new_idx    = used_q[IdxW-1:0];
  assign pool_empty = used_q >= NodeLimit;
  assign key_nz     = |in_data_i.mask[LoadBits-1:0];
  assign links_set  = key_bit[0] ? {new_idx, links[IdxW-1:0]}
                                 : {links[2*IdxW-1:IdxW], new_idx};

  // walk / allocate sequencer
  always_comb begin
    state_d     = state_q;
    is_query_d  = is_query_q;
    at_root_d   = at_root_q;
    cur_d       = cur_q;
    used_d      = used_q;
    root_d      = root_q;
    res_found_d = res_found_q;
    res_full_d  = res_full_q;
    shift       = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = cur_q;
    mem_wdata   = '0;
    mem_re      = 1'b0;
    mem_raddr   = child;
    load_out    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          is_query_d = (in_data_i.func == bbt_pkg::FuncQuery);
          at_root_d  = 1'b1;
          if (key_nz) begin
            state_d = ST_WALK;
          end else begin
            res_found_d = (in_data_i.func == bbt_pkg::FuncQuery);
            res_full_d  = 1'b0;
            state_d     = ST_RESP;
          end
        end
      end
      ST_WALK: begin
        if (child != '0) begin
          shift     = 1'b1;
          cur_d     = child;
          at_root_d = 1'b0;
          if (key_any[1]) begin
            mem_re = 1'b1;
          end else begin
            res_found_d = is_query_q;
            res_full_d  = 1'b0;
            state_d     = ST_RESP;
          end
        end else if (is_query_q) begin
          res_found_d = 1'b0;
          res_full_d  = 1'b0;
          state_d     = ST_RESP;
        end else if (pool_empty) begin
          res_found_d = 1'b0;
          res_full_d  = 1'b1;
          state_d     = ST_RESP;
        end else begin
          used_d = used_q + 1'b1;
          if (at_root_q) begin
            root_d = links_set;
          end else begin
            mem_we    = 1'b1;
            mem_wdata = links_set;
          end
          cur_d     = new_idx;
          at_root_d = 1'b0;
          shift     = 1'b1;
          state_d   = ST_ALLOC;
        end
      end
      ST_ALLOC: begin
        // cur_q is a fresh node: write its links once
        mem_we = 1'b1;
        if (!key_any[0] || pool_empty) begin
          mem_wdata   = '0;
          res_found_d = 1'b0;
          res_full_d  = key_any[0];
          state_d     = ST_RESP;
        end else begin
          mem_wdata = key_bit[0] ? {new_idx, {IdxW{1'b0}}} : {{IdxW{1'b0}}, new_idx};
          used_d    = used_q + 1'b1;
          cur_d     = new_idx;
          shift     = 1'b1;
        end
      end
      ST_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (load_out) begin
      out_valid_d     = 1'b1;
      out_d.found     = res_found_q;
      out_d.pool_full = res_full_q;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      used_q      <= CntW'(1);
      root_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      root_q      <= root_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    is_query_q  <= is_query_d;
    at_root_q   <= at_root_d;
    cur_q       <= cur_d;
    res_found_q <= res_found_d;
    res_full_q  <= res_full_d;
    out_q       <= out_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign walk_query = (state_q == ST_WALK) && is_query_q;

  `BBT_ASSERT(a_used_bound, (used_q <= NodeLimit && used_q != '0), "node count out of range")
  `BBT_ASSERT_NEXT(a_used_mono, 1'b1, (used_q >= $past(used_q)), "node count decreased")
  `BBT_ASSERT_NEXT(a_query_no_alloc, walk_query, used_q == $past(used_q), "query allocated")
  `BBT_ASSERT(a_load_in_resp, $rose(out_valid_q) |-> ($past(state_q) == ST_RESP), "bad load")

endmodule
